// File: design/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared assertion forms for the checker of the double-ended queue.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Checked on every rising clock edge while reset is released.
`define DEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, also while reset is applied.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation, status, cell control and sequencer types of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_DUMPED = 2'd3
	} status_t;

	// What one cell loads at the next edge.
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LEFT  = 2'd1,
		SEL_RIGHT = 2'd2,
		SEL_LOAD  = 2'd3
	} cell_sel_t;

	// What the whole row does at the next edge.
	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_APPEND    = 3'd1,
		ACT_PREPEND   = 3'd2,
		ACT_SHIFT_OUT = 3'd3,
		ACT_ROTATE    = 3'd4
	} row_act_t;

	typedef enum logic {
		MODE_IDLE = 1'b0,
		MODE_DUMP = 1'b1
	} mode_t;

endpackage

`default_nettype wire

// File: design/deq_req_if.sv
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel that carries one operation request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
	logic                               valid;
	logic                               ready;
	logic [deq_pkg::OP_W-1:0]           op;
	logic [deq_pkg::VALUE_W-1:0]        value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// File: design/deq_rsp_if.sv
// ----------------------------------------------------------------------------
// Double-ended queue response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [deq_pkg::STATUS_W-1:0]       status;
	logic [deq_pkg::VALUE_W-1:0]        entry;
	logic [deq_pkg::OCC_W-1:0]          occupancy;
	logic                               last;

	modport source (output valid, output status, output entry, output occupancy,
		output last, input ready);
	modport sink (input valid, input status, input entry, input occupancy,
		input last, output ready);
endinterface

`default_nettype wire

// File: design/deq_cell.sv
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One storage position of the queue row; takes a neighbor's word or new data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire deq_pkg::cell_sel_t    sel,
	input  wire logic [DATA_WIDTH-1:0] left_d,
	input  wire logic [DATA_WIDTH-1:0] right_d,
	input  wire logic [DATA_WIDTH-1:0] load_d,
	output logic      [DATA_WIDTH-1:0] data_q
);

	always_ff @(posedge clk) begin
		case (sel)
			deq_pkg::SEL_LEFT:  data_q <= left_d;
			deq_pkg::SEL_RIGHT: data_q <= right_d;
			deq_pkg::SEL_LOAD:  data_q <= load_d;
			default:            data_q <= data_q;
		endcase
	end

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque held in a row of cells, front entry always in cell zero.
// ----------------------------------------------------------------------------
// The queue keeps its entries in order in a row of DEPTH cells, the front in
// cell zero. A push at the back loads the cell just past the last entry, a
// push at the front shifts the row one place back, a pop at the front shifts
// it one place forward and a pop at the back only lowers the count. Every
// push, pop or unused op code returns exactly one result beat, so such
// requests are accepted back to back as long as the result side keeps up.
// A dump returns one result beat per held entry once it is accepted: the
// row rotates by one cell per result beat, reading the front cell, and ends
// in its original order. No request is accepted while a dump is running.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	deq_pkg::cell_sel_t    cell_sel [DEPTH];

	deq_pkg::mode_t   mode_q, mode_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    idx_q, idx_d;
	deq_pkg::row_act_t act;
	logic [DATA_WIDTH-1:0] load_data;
	logic [DATA_WIDTH-1:0] value_ext;

	logic                            rsp_valid_q, rsp_valid_d;
	logic                            rsp_load;
	deq_pkg::status_t                stat_d;
	logic [deq_pkg::VALUE_W-1:0]     entry_d;
	logic                            last_d;
	deq_pkg::status_t                rsp_status_q;
	logic [deq_pkg::VALUE_W-1:0]     rsp_entry_q;
	logic [deq_pkg::OCC_W-1:0]       rsp_occ_q;
	logic                            rsp_last_q;

	logic out_free;
	logic accept;

	assign value_ext = DATA_WIDTH'(req.value);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (mode_q == deq_pkg::MODE_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	always_comb begin
		mode_d      = mode_q;
		count_d     = count_q;
		idx_d       = idx_q;
		act         = deq_pkg::ACT_NONE;
		load_data   = value_ext;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		rsp_load    = 1'b0;
		stat_d      = deq_pkg::STAT_DONE;
		entry_d     = '0;
		last_d      = 1'b1;

		if (accept) begin
			rsp_load = 1'b1;
			case (deq_pkg::op_t'(req.op))
				deq_pkg::OP_PUSH_BACK: begin
					if (count_q == FULL_COUNT) begin
						stat_d = deq_pkg::STAT_FULL;
					end else begin
						act     = deq_pkg::ACT_APPEND;
						count_d = count_q + 1'b1;
					end
				end
				deq_pkg::OP_PUSH_FRONT: begin
					if (count_q == FULL_COUNT) begin
						stat_d = deq_pkg::STAT_FULL;
					end else begin
						act     = deq_pkg::ACT_PREPEND;
						count_d = count_q + 1'b1;
					end
				end
				deq_pkg::OP_POP_FRONT: begin
					if (count_q == '0) begin
						stat_d = deq_pkg::STAT_EMPTY;
					end else begin
						act     = deq_pkg::ACT_SHIFT_OUT;
						count_d = count_q - 1'b1;
					end
				end
				deq_pkg::OP_POP_BACK: begin
					if (count_q == '0) begin
						stat_d = deq_pkg::STAT_EMPTY;
					end else begin
						count_d = count_q - 1'b1;
					end
				end
				deq_pkg::OP_DUMP: begin
					if (count_q == '0) begin
						stat_d = deq_pkg::STAT_EMPTY;
					end else begin
						// Results come from the dump sequence that follows.
						rsp_load = 1'b0;
						mode_d   = deq_pkg::MODE_DUMP;
						idx_d    = '0;
					end
				end
				default: begin
					stat_d = deq_pkg::STAT_DONE;
				end
			endcase
		end else if (mode_q == deq_pkg::MODE_DUMP && out_free) begin
			// The front word goes out and wraps around to the back of the row.
			act       = deq_pkg::ACT_ROTATE;
			load_data = cell_q[0];
			rsp_load  = 1'b1;
			stat_d    = deq_pkg::STAT_DUMPED;
			entry_d   = deq_pkg::VALUE_W'(cell_q[0]);
			last_d    = (idx_q == count_q - 1'b1);
			idx_d     = idx_q + 1'b1;
			if (last_d) begin
				mode_d = deq_pkg::MODE_IDLE;
			end
		end

		if (rsp_load) begin
			rsp_valid_d = 1'b1;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		localparam logic [CW-1:0] IDX = CW'(i);
		localparam logic [CW-1:0] NXT = CW'(i + 1);

		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end

		always_comb begin
			case (act)
				deq_pkg::ACT_APPEND:
					cell_sel[i] = (IDX == count_q) ? deq_pkg::SEL_LOAD : deq_pkg::SEL_HOLD;
				deq_pkg::ACT_PREPEND:
					cell_sel[i] = (i == 0) ? deq_pkg::SEL_LOAD : deq_pkg::SEL_LEFT;
				deq_pkg::ACT_SHIFT_OUT:
					cell_sel[i] = deq_pkg::SEL_RIGHT;
				deq_pkg::ACT_ROTATE: begin
					if (NXT == count_q) begin
						cell_sel[i] = deq_pkg::SEL_LOAD;
					end else if (IDX < count_q) begin
						cell_sel[i] = deq_pkg::SEL_RIGHT;
					end else begin
						cell_sel[i] = deq_pkg::SEL_HOLD;
					end
				end
				default:
					cell_sel[i] = deq_pkg::SEL_HOLD;
			endcase
		end

		deq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.sel     (cell_sel[i]),
			.left_d  (left_d),
			.right_d (right_d),
			.load_d  (load_data),
			.data_q  (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= deq_pkg::MODE_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			mode_q      <= mode_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= stat_d;
			rsp_entry_q  <= entry_d;
			rsp_occ_q    <= deq_pkg::OCC_W'(count_d);
			rsp_last_q   <= last_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.entry     = rsp_entry_q;
	assign rsp.occupancy = rsp_occ_q;
	assign rsp.last      = rsp_last_q;

endmodule

`default_nettype wire

// File: design/deq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions on the result channel of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_defines.svh"

module deq_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               req_ready,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic [deq_pkg::STATUS_W-1:0]       status,
	input wire logic [deq_pkg::VALUE_W-1:0]        entry,
	input wire logic [deq_pkg::OCC_W-1:0]          occupancy,
	input wire logic                               last
);

	// Only a dumped entry carries data.
	`DEQ_ASSERT(a_entry_zero, rsp_valid && status != deq_pkg::STAT_DUMPED |-> entry == '0, "non-dump result with nonzero entry")

	// An empty report always closes its request with nothing held.
	`DEQ_ASSERT(a_empty_beat, rsp_valid && status == deq_pkg::STAT_EMPTY |-> occupancy == '0 && last, "empty status with entries or without last")

	// While a dump is still running, no new request can be taken.
	`DEQ_ASSERT(a_dump_busy, rsp_valid && status == deq_pkg::STAT_DUMPED && !last |-> !req_ready, "request taken in the middle of a dump")

	// A stalled beat holds.
	`DEQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry) && $stable(last), "result changed while stalled")

	// While reset is applied the result channel goes quiet, also at the very first edge.
	`DEQ_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !rsp_valid, "result valid during reset")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.entry     (rsp.entry),
	.occupancy (rsp.occupancy),
	.last      (rsp.last)
);

`default_nettype wire
